// ===== sv/cls_pkg.sv =====
package cls_pkg;

  // Width of the backslash and argument counters; both saturate at all ones.
  localparam int unsigned COUNT_WIDTH = 16;

  // Output field widths are fixed.
  localparam int unsigned REP_WIDTH = 16;
  localparam int unsigned MAX_RES   = 3;

  // Entries in the queue between front and back.
  localparam int unsigned QDEPTH = 2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_ARG_END  = 2'd1,
    KIND_LINE_END = 2'd2,
    KIND_EMPTY    = 2'd3
  } kind_e;

  // One result word.
  typedef struct packed {
    kind_e                kind;
    logic [7:0]           char_out;
    logic [REP_WIDTH-1:0] repeat_res;
    logic [REP_WIDTH-1:0] arg_total;
  } res_t;

  // All results caused by one input byte, packed from slot 0.
  typedef struct packed {
    logic [1:0]          cnt;
    res_t [MAX_RES-1:0]  slot;
  } entry_t;

  // Counter value masked to an output field.
  function automatic logic [REP_WIDTH-1:0] to_field(cnt_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[REP_WIDTH-1:0];
  endfunction

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

endpackage

// ===== sv/cls_byte_if.sv =====
interface cls_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

// ===== sv/cls_res_if.sv =====
interface cls_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  char_out;
  logic [15:0] repeat_res;
  logic [15:0] arg_total;
  logic        last;

  modport source (output valid, output kind, output char_out, output repeat_res,
                  output arg_total, output last, input ready);
  modport sink   (input valid, input kind, input char_out, input repeat_res,
                  input arg_total, input last, output ready);
endinterface

// ===== sv/command_line_splitter.sv =====
// Command line splitter. Takes one byte of a command line per word (byte 0 ends
// the line) and emits result words: character runs (backslash runs come as one
// word with a repeat count), argument ends, and a line end carrying the argument
// count, or an empty-line error for a bare byte 0. The first argument is the
// program path with literal backslashes; later arguments follow the Windows
// backslash and quote rules. Input bytes are taken one per cycle while the queue
// has room; a byte that causes k results yields k output words, and the two-entry
// queue between the byte classifier and the output sequencer keeps the input
// running while those words drain. Bytes that cause no result take no entry. The
// input stalls only while both entries are taken, that is when the output side is
// two result-producing bytes behind. No clearing pass after reset.
module command_line_splitter
  import cls_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  cls_byte_if.sink  byte_i,
  cls_res_if.source res_o
);

  logic   push, full, pop, q_valid;
  entry_t entry, head;

  cls_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  cls_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  cls_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .head_i  (head),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

// ===== sv/cls_front.sv =====
module cls_front
  import cls_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  cls_byte_if.sink   byte_i,
  input  logic       full_i,
  output logic       push_o,
  output entry_t     entry_o
);

  typedef enum logic [4:0] {
    PH_LINE_START  = 5'b00001,
    PH_PATH_QUOTED = 5'b00010,
    PH_PATH_PLAIN  = 5'b00100,
    PH_GAP         = 5'b01000,
    PH_ARG         = 5'b10000
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [1:0] qc_q, qc_d;
  logic       iqr_q, iqr_d;
  cnt_t       pend_q, pend_d;
  cnt_t       argc_q, argc_d;

  logic       acc;
  logic [7:0] b;
  logic       blank;

  // Working copies for argument bytes
  logic       do_arg;
  logic [1:0] qe;
  logic       ie;
  cnt_t       pe;

  // Candidate results: backslash flush, primary, line end
  logic       a_en;
  cnt_t       a_cnt;
  logic       b_en;
  kind_e      b_kind;
  logic [7:0] b_char;
  logic       c_en;
  logic       clear;

  assign byte_i.ready = !full_i;
  assign acc          = byte_i.valid && !full_i;
  assign b            = byte_i.byte_in;
  assign blank        = (b == CH_SPACE) || (b == CH_TAB);

  // Byte classification and state update
  always_comb begin
    phase_d = phase_q;
    qc_d    = qc_q;
    iqr_d   = iqr_q;
    pend_d  = pend_q;
    argc_d  = argc_q;
    do_arg  = 1'b0;
    qe      = qc_q;
    ie      = iqr_q;
    pe      = pend_q;
    a_en    = 1'b0;
    a_cnt   = '0;
    b_en    = 1'b0;
    b_kind  = KIND_CHAR;
    b_char  = CH_NUL;
    c_en    = 1'b0;
    clear   = 1'b0;

    case (phase_q)
      PH_PATH_QUOTED: begin
        if (b == CH_NUL) begin
          b_en   = 1'b1;
          b_kind = KIND_ARG_END;
          c_en   = 1'b1;
          clear  = 1'b1;
        end else if (b == CH_QUOTE) begin
          b_en    = 1'b1;
          b_kind  = KIND_ARG_END;
          phase_d = PH_GAP;
        end else begin
          b_en   = 1'b1;
          b_char = b;
        end
      end
      PH_PATH_PLAIN: begin
        if (b == CH_NUL) begin
          b_en   = 1'b1;
          b_kind = KIND_ARG_END;
          c_en   = 1'b1;
          clear  = 1'b1;
        end else if (blank) begin
          b_en    = 1'b1;
          b_kind  = KIND_ARG_END;
          phase_d = PH_GAP;
        end else begin
          b_en   = 1'b1;
          b_char = b;
        end
      end
      PH_GAP: begin
        if (b == CH_NUL) begin
          c_en  = 1'b1;
          clear = 1'b1;
        end else if (!blank) begin
          argc_d = sat_inc(argc_q);
          qe     = 2'd0;
          ie     = 1'b0;
          pe     = '0;
          do_arg = 1'b1;
        end
      end
      PH_ARG: begin
        do_arg = 1'b1;
      end
      default: begin
        if (b == CH_NUL) begin
          b_en   = 1'b1;
          b_kind = KIND_EMPTY;
          clear  = 1'b1;
        end else begin
          argc_d = cnt_t'(1);
          if (b == CH_QUOTE) begin
            phase_d = PH_PATH_QUOTED;
          end else if (blank) begin
            b_en    = 1'b1;
            b_kind  = KIND_ARG_END;
            phase_d = PH_GAP;
          end else begin
            b_en    = 1'b1;
            b_char  = b;
            phase_d = PH_PATH_PLAIN;
          end
        end
      end
    endcase

    // Argument bytes: backslash and quote rules
    if (do_arg) begin
      if (ie && (b != CH_QUOTE)) begin
        if (qe == 2'd2) begin
          qe = 2'd0;
        end
        ie = 1'b0;
      end
      phase_d = PH_ARG;
      qc_d    = qe;
      iqr_d   = ie;
      pend_d  = pe;
      if (b == CH_NUL) begin
        a_en   = 1'b1;
        a_cnt  = pe;
        b_en   = 1'b1;
        b_kind = KIND_ARG_END;
        c_en   = 1'b1;
        clear  = 1'b1;
      end else if (blank && (qe == 2'd0)) begin
        a_en    = 1'b1;
        a_cnt   = pe;
        b_en    = 1'b1;
        b_kind  = KIND_ARG_END;
        pend_d  = '0;
        phase_d = PH_GAP;
      end else if (b == CH_BSLASH) begin
        pend_d = sat_inc(pe);
      end else if (b == CH_QUOTE) begin
        if (ie) begin
          qc_d = qe + 2'd1;
          if (qc_d == 2'd3) begin
            b_en   = 1'b1;
            b_char = CH_QUOTE;
            qc_d   = 2'd0;
          end
        end else if (!pe[0]) begin
          a_en  = 1'b1;
          a_cnt = pe >> 1;
          qc_d  = qe + 2'd1;
        end else begin
          a_en   = 1'b1;
          a_cnt  = pe >> 1;
          b_en   = 1'b1;
          b_char = CH_QUOTE;
        end
        pend_d = '0;
        iqr_d  = 1'b1;
      end else begin
        a_en   = 1'b1;
        a_cnt  = pe;
        b_en   = 1'b1;
        b_char = b;
        pend_d = '0;
      end
    end

    if (clear) begin
      phase_d = PH_LINE_START;
      qc_d    = 2'd0;
      iqr_d   = 1'b0;
      pend_d  = '0;
      argc_d  = '0;
    end
  end

  // Pack present results in order
  always_comb begin
    entry_o = '0;
    if (a_en && (a_cnt != '0)) begin
      entry_o.slot[entry_o.cnt] = '{kind: KIND_CHAR, char_out: CH_BSLASH,
                                    repeat_res: to_field(a_cnt), arg_total: '0};
      entry_o.cnt = entry_o.cnt + 2'd1;
    end
    if (b_en) begin
      entry_o.slot[entry_o.cnt] = '{kind: b_kind, char_out: b_char,
                                    repeat_res: (b_kind == KIND_CHAR) ? 16'd1 : 16'd0,
                                    arg_total: '0};
      entry_o.cnt = entry_o.cnt + 2'd1;
    end
    if (c_en) begin
      entry_o.slot[entry_o.cnt] = '{kind: KIND_LINE_END, char_out: CH_NUL,
                                    repeat_res: '0, arg_total: to_field(argc_q)};
      entry_o.cnt = entry_o.cnt + 2'd1;
    end
  end

  assign push_o = acc && (entry_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LINE_START;
      qc_q    <= 2'd0;
      iqr_q   <= 1'b0;
      pend_q  <= '0;
      argc_q  <= '0;
    end else if (acc) begin
      phase_q <= phase_d;
      qc_q    <= qc_d;
      iqr_q   <= iqr_d;
      pend_q  <= pend_d;
      argc_q  <= argc_d;
    end
  end

endmodule

// ===== sv/cls_queue.sv =====
module cls_queue
  import cls_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t head_o
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  entry_t             mem_q [QDEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == CNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/cls_back.sv =====
module cls_back
  import cls_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  entry_t    head_i,
  output logic      pop_o,
  cls_res_if.source res_o
);

  logic [1:0] idx_q, idx_d;
  res_t       cur;
  logic       is_last;
  logic       fire;

  // Walk the slots of the head entry, one word per cycle while the output is ready
  assign cur     = head_i.slot[idx_q];
  assign is_last = (idx_q == head_i.cnt - 2'd1);
  assign fire    = valid_i && res_o.ready;
  assign pop_o   = fire && is_last;

  assign res_o.valid      = valid_i;
  assign res_o.kind       = cur.kind;
  assign res_o.char_out   = cur.char_out;
  assign res_o.repeat_res = cur.repeat_res;
  assign res_o.arg_total  = cur.arg_total;
  assign res_o.last       = is_last;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
